[sv/two_pkg.sv]
// shared types and constants for the tracking wheel odometry block
// used by two_cordic and tracking_wheel_odometry_top; depends on nothing
`default_nettype none

package two_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TRIG_BITS = 30;
  localparam int ATAN_MAX  = 24;

  localparam logic [4:0] FRAC_SH = 5'd16;
  localparam logic [4:0] TRIG_SH = 5'd30;

  // cordic angle domain, degrees in q30
  localparam logic signed [41:0] D90  = 42'sd96636764160;
  localparam logic signed [41:0] D180 = 42'sd193273528320;
  localparam logic signed [41:0] D360 = 42'sd386547056640;

  // heading domain, degrees in q16
  localparam logic signed [27:0] H180 = 28'sd11796480;
  localparam logic signed [27:0] H360 = 28'sd23592960;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] PI_OVER_180_Q30 = 34'sd18740330;
  // ceil(2^33 / 3), exact divide by three for 32-bit magnitudes
  localparam logic signed [33:0] RECIP3 = 34'sd2863311531;

  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  localparam logic [2:0] REG_FRONT = 3'd0;
  localparam logic [2:0] REG_BACK  = 3'd1;
  localparam logic [2:0] REG_RIGHT = 3'd2;
  localparam logic [2:0] REG_LEFT  = 3'd3;
  localparam logic [2:0] REG_HCNT  = 3'd4;
  localparam logic [2:0] REG_VCNT  = 3'd5;

  typedef struct packed {
    logic               start;
    logic signed [25:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] sin_v;
    logic signed [33:0] cos_v;
  } trig_res_t;

  function automatic logic signed [36:0] atan_deg(input logic [4:0] idx);
    logic signed [36:0] v;
    case (idx)
      5'd0:  v = 37'sd48318382080;
      5'd1:  v = 37'sd28524006506;
      5'd2:  v = 37'sd15071301663;
      5'd3:  v = 37'sd7650428050;
      5'd4:  v = 37'sd3840059795;
      5'd5:  v = 37'sd1921901881;
      5'd6:  v = 37'sd961185452;
      5'd7:  v = 37'sd480622056;
      5'd8:  v = 37'sd240314695;
      5'd9:  v = 37'sd120157806;
      5'd10: v = 37'sd60078960;
      5'd11: v = 37'sd30039487;
      5'd12: v = 37'sd15019745;
      5'd13: v = 37'sd7509872;
      5'd14: v = 37'sd3754936;
      5'd15: v = 37'sd1877468;
      5'd16: v = 37'sd938734;
      5'd17: v = 37'sd469367;
      5'd18: v = 37'sd234683;
      5'd19: v = 37'sd117342;
      5'd20: v = 37'sd58671;
      5'd21: v = 37'sd29335;
      5'd22: v = 37'sd14668;
      5'd23: v = 37'sd7334;
      default: v = 37'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/two_cordic.sv]
// iterative rotation-mode cordic, one micro-rotation per cycle
// returns sin and cos in q30 of a q16 degree angle; uses two_pkg
`default_nettype none

module two_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire two_pkg::trig_req_t req,
  output two_pkg::trig_res_t      res
);

  localparam int IW = $clog2(CORDIC_STEPS);

  typedef enum logic [2:0] {C_IDLE, C_F1, C_F2, C_F90, C_RUN, C_FLIP} cst_t;

  cst_t               state_r;
  logic [IW-1:0]      i_r;
  logic signed [41:0] z_r;
  logic signed [33:0] x_r, y_r;
  logic               flip_r;
  logic               done_r;

  logic signed [33:0] xs, ys;
  logic signed [36:0] at;
  logic signed [41:0] zfold;

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = two_pkg::atan_deg(5'(i_r));
    if (z_r > two_pkg::D180) begin
      zfold = z_r - two_pkg::D360;
    end else if (z_r < -two_pkg::D180) begin
      zfold = z_r + two_pkg::D360;
    end else begin
      zfold = z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      i_r     <= '0;
      flip_r  <= 1'b0;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (req.start) begin
            z_r     <= {{2{req.angle[25]}}, req.angle, 14'b0};
            done_r  <= 1'b0;
            state_r <= C_F1;
          end
        end
        C_F1: begin
          z_r     <= zfold;
          state_r <= C_F2;
        end
        C_F2: begin
          z_r     <= zfold;
          state_r <= C_F90;
        end
        C_F90: begin
          if (z_r > two_pkg::D90) begin
            z_r    <= z_r - two_pkg::D180;
            flip_r <= 1'b1;
          end else if (z_r < -two_pkg::D90) begin
            z_r    <= z_r + two_pkg::D180;
            flip_r <= 1'b1;
          end else begin
            flip_r <= 1'b0;
          end
          x_r     <= two_pkg::CORDIC_GAIN_Q30;
          y_r     <= '0;
          i_r     <= '0;
          state_r <= C_RUN;
        end
        C_RUN: begin
          if (!z_r[41]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - 42'(at);
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + 42'(at);
          end
          if (i_r == IW'(CORDIC_STEPS - 1)) begin
            state_r <= C_FLIP;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        C_FLIP: begin
          if (flip_r) begin
            x_r <= -x_r;
            y_r <= -y_r;
          end
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign res.done  = done_r;
  assign res.sin_v = y_r;
  assign res.cos_v = x_r;

endmodule

`default_nettype wire

[sv/tracking_wheel_odometry_top.sv]
// top level of the tracking wheel odometry block: sequencer, shared multiplier
// and position state; uses two_pkg and two_cordic
`default_nettype none

// Odometry from two tracking wheels and an IMU heading. Each request carries the
// cumulative wheel distances and the heading (Q10.16, degrees); one result with
// the saturated field x, y and the heading comes back for each request. When the
// result is taken at once, the pace of items is set by the iterative cordic, which
// runs next to a sequence of thirteen steps on one shared 34x34 multiplier
// (rotation correction, divide by wheel count, rotation into the field frame).
// in_tready is high only while the sequencer is idle; a finished result waits in
// an output register while the next request is taken.
// Configuration writes are taken at any time but must only come while idle.
module tracking_wheel_odometry_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // horiz_distance[31:0], vert_distance[63:32], imu_heading[89:64], zero pad
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pos_x[31:0], pos_y[63:32], heading_out[89:64], zero pad
  output logic [95:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_RAD, S_RADR, S_CH, S_CV, S_DH, S_DV, S_DDY, S_WAIT,
    S_M0, S_M1, S_M2, S_M3, S_FIN
  } st_t;

  st_t                state_r;
  logic signed [23:0] front_r, back_r, right_r, left_r;
  logic [1:0]         hcnt_r, vcnt_r;
  logic [31:0]        last_h_r, last_v_r;
  logic [25:0]        last_hd_r;
  logic signed [31:0] field_x_r, field_y_r;

  logic signed [25:0] head_r;
  logic signed [27:0] dth_r;
  logic signed [31:0] dh_r, dv_r;
  logic signed [24:0] hdiff_r, vdiff_r;
  logic signed [23:0] rad_r;
  logic signed [31:0] ch_r, cv_r;
  logic signed [32:0] ddx_r, ddy_r;
  logic signed [35:0] t_r, mx_r;
  logic signed [67:0] prod_r;

  logic               out_valid_r;
  logic [31:0]        out_x_r, out_y_r;
  logic [25:0]        out_hd_r;

  two_pkg::trig_req_t treq;
  two_pkg::trig_res_t tres;

  logic signed [33:0] op_a, op_b;
  logic signed [27:0] dth_raw, dth_fold;
  logic signed [67:0] r30, r16;
  logic signed [36:0] acc_x, acc_y;
  logic               in_acc, fin_ok;

  function automatic logic signed [67:0] rnd(input logic signed [67:0] v,
                                             input logic [4:0] n);
    logic signed [67:0] h;
    h = 68'sd1 <<< (n - 5'd1);
    return (v + h) >>> n;
  endfunction

  function automatic logic signed [33:0] mag(input logic signed [31:0] c);
    logic signed [33:0] e;
    e = 34'(c);
    return c[31] ? -e : e;
  endfunction

  // truncating divide of the correction by the wheel count
  function automatic logic signed [31:0] corr(input logic signed [31:0] c,
                                              input logic signed [67:0] p,
                                              input logic [1:0] cnt);
    logic [32:0] m;
    logic [32:0] q;
    m = 33'(mag(c));
    case (cnt)
      two_pkg::CNT_ONE:   q = m;
      two_pkg::CNT_TWO:   q = m >> 1;
      two_pkg::CNT_THREE: q = {2'b0, p[63:33]};
      default:            q = '0;
    endcase
    return c[31] ? -32'(q) : 32'(q);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'h7fffffff;
    end else if (v < -37'sd2147483648) begin
      return 32'h80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign fin_ok     = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_hd_r, out_y_r, out_x_r};

  assign treq.start = in_acc;
  assign treq.angle = in_tdata[89:64];

  two_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (treq),
    .res   (tres)
  );

  always_comb begin
    dth_raw = 28'(signed'(in_tdata[89:64])) - 28'(signed'(last_hd_r));
    if (dth_raw > two_pkg::H180) begin
      dth_fold = dth_raw - two_pkg::H360;
    end else if (dth_raw < -two_pkg::H180) begin
      dth_fold = dth_raw + two_pkg::H360;
    end else begin
      dth_fold = dth_raw;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_RAD: begin op_a = 34'(dth_r); op_b = two_pkg::PI_OVER_180_Q30; end
      S_CH:  begin op_a = 34'(rad_r); op_b = 34'(hdiff_r); end
      S_CV:  begin op_a = 34'(rad_r); op_b = 34'(vdiff_r); end
      S_DH:  begin op_a = mag(ch_r); op_b = two_pkg::RECIP3; end
      S_DV:  begin op_a = mag(cv_r); op_b = two_pkg::RECIP3; end
      S_M0:  begin op_a = 34'(ddy_r); op_b = tres.sin_v; end
      S_M1:  begin op_a = 34'(ddx_r); op_b = tres.cos_v; end
      S_M2:  begin op_a = 34'(ddy_r); op_b = tres.cos_v; end
      S_M3, S_FIN: begin op_a = 34'(ddx_r); op_b = tres.sin_v; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    r30   = rnd(prod_r, two_pkg::TRIG_SH);
    r16   = rnd(prod_r, two_pkg::FRAC_SH);
    acc_x = 37'(field_x_r) + 37'(mx_r);
    acc_y = 37'(field_y_r) + 37'(t_r) + 37'(signed'(r30[35:0]));
  end

  always_ff @(posedge clk) begin
    prod_r <= 68'(op_a) * 68'(op_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      right_r     <= '0;
      left_r      <= '0;
      hcnt_r      <= two_pkg::CNT_ONE;
      vcnt_r      <= two_pkg::CNT_ONE;
      last_h_r    <= '0;
      last_v_r    <= '0;
      last_hd_r   <= '0;
      field_x_r   <= '0;
      field_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          two_pkg::REG_FRONT: front_r <= cfg_data;
          two_pkg::REG_BACK:  back_r  <= cfg_data;
          two_pkg::REG_RIGHT: right_r <= cfg_data;
          two_pkg::REG_LEFT:  left_r  <= cfg_data;
          two_pkg::REG_HCNT:  hcnt_r  <= cfg_data[1:0];
          two_pkg::REG_VCNT:  vcnt_r  <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            head_r    <= in_tdata[89:64];
            dth_r     <= dth_fold;
            dh_r      <= in_tdata[31:0] - last_h_r;
            dv_r      <= in_tdata[63:32] - last_v_r;
            hdiff_r   <= 25'(front_r) - 25'(back_r);
            vdiff_r   <= 25'(right_r) - 25'(left_r);
            last_h_r  <= in_tdata[31:0];
            last_v_r  <= in_tdata[63:32];
            last_hd_r <= in_tdata[89:64];
            state_r   <= S_RAD;
          end
        end
        S_RAD:  state_r <= S_RADR;
        S_RADR: begin
          rad_r   <= r30[23:0];
          state_r <= S_CH;
        end
        S_CH:   state_r <= S_CV;
        S_CV: begin
          ch_r    <= r16[31:0];
          state_r <= S_DH;
        end
        S_DH: begin
          cv_r    <= r16[31:0];
          state_r <= S_DV;
        end
        S_DV: begin
          ddx_r   <= 33'(dh_r) + 33'(corr(ch_r, prod_r, hcnt_r));
          state_r <= S_DDY;
        end
        S_DDY: begin
          ddy_r   <= 33'(dv_r) + 33'(corr(cv_r, prod_r, vcnt_r));
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (tres.done) begin
            state_r <= S_M0;
          end
        end
        S_M0:   state_r <= S_M1;
        S_M1: begin
          t_r     <= r30[35:0];
          state_r <= S_M2;
        end
        S_M2: begin
          mx_r    <= t_r - r30[35:0];
          state_r <= S_M3;
        end
        S_M3: begin
          t_r     <= r30[35:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          // prod_r holds ddx*sin until the result slot frees up
          if (fin_ok) begin
            field_x_r   <= sat32(acc_x);
            field_y_r   <= sat32(acc_y);
            out_x_r     <= sat32(acc_x);
            out_y_r     <= sat32(acc_y);
            out_hd_r    <= head_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/two_checker.sv]
// port-level checks for tracking_wheel_odometry_top, attached with bind
// depends only on the top level's ports
`default_nettype none

module two_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [95:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata
);

  logic [25:0] hd_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hd_r <= in_tdata[89:64];
    end
  end

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_heading: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> out_tdata[89:64] == hd_r)
    else $error("heading does not match last request");

endmodule

bind tracking_wheel_odometry_top two_checker u_two_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for tracking_wheel_odometry_top: random and directed
// requests, an odometry predictor in a scoreboard class; depends on two_pkg
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam longint DEG180 = 64'sd11796480;
  localparam longint DEG90 = 64'sd5898240;
  localparam longint DEG360 = 64'sd23592960;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [25:0] heading;
  } pose_t;

  class odo_scoreboard;
    logic signed [23:0] front, back, right, left;
    logic [1:0] hcnt, vcnt;
    logic [31:0] last_h, last_v;
    logic signed [25:0] last_hd;
    longint fx, fy;
    pose_t pending[$];
    int errors;
    longint atan_tab[16];

    function new();
      atan_tab = '{64'sd48318382080, 64'sd28524006506, 64'sd15071301663,
                   64'sd7650428050, 64'sd3840059795, 1921901881, 961185452,
                   480622056, 240314695, 120157806, 60078960, 30039487,
                   15019745, 7509872, 3754936, 1877468};
      front = 0; back = 0; right = 0; left = 0;
      hcnt = two_pkg::CNT_ONE; vcnt = two_pkg::CNT_ONE;
      last_h = 0; last_v = 0; last_hd = 0;
      fx = 0; fy = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        two_pkg::REG_FRONT: front = val;
        two_pkg::REG_BACK:  back = val;
        two_pkg::REG_RIGHT: right = val;
        two_pkg::REG_LEFT:  left = val;
        two_pkg::REG_HCNT:  hcnt = val[1:0];
        two_pkg::REG_VCNT:  vcnt = val[1:0];
        default: ;
      endcase
    endfunction

    function longint rnd_shr(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint wheel_corr(longint rad, longint diff, logic [1:0] cnt);
      longint c;
      c = rnd_shr(rad * diff, two_pkg::FRAC_BITS);
      if (cnt == 2'd0) return 0;
      return c / longint'({62'd0, cnt});
    endfunction

    function void note_request(logic [95:0] d);
      logic [31:0] h, v, t;
      logic signed [25:0] hd;
      longint dh, dv, dth, rad, ddx, ddy, z, x, y, nx, mx, my;
      bit flip;
      pose_t p;
      h = d[31:0]; v = d[63:32]; hd = d[89:64];
      t = h - last_h; dh = longint'($signed(t));
      t = v - last_v; dv = longint'($signed(t));
      dth = longint'(hd) - longint'(last_hd);
      if (dth > DEG180) dth -= DEG360;
      else if (dth < -DEG180) dth += DEG360;
      rad = rnd_shr(dth * longint'(two_pkg::PI_OVER_180_Q30), two_pkg::TRIG_BITS);
      ddx = dh + wheel_corr(rad, longint'(front) - longint'(back), hcnt);
      ddy = dv + wheel_corr(rad, longint'(right) - longint'(left), vcnt);
      // heading to q30 degrees, fold into the cordic range
      z = longint'(hd) * 16384;
      for (int k = 0; k < 2; k++) begin
        if (z > (DEG180 <<< 14)) z -= DEG360 <<< 14;
        else if (z < -(DEG180 <<< 14)) z += DEG360 <<< 14;
      end
      flip = 0;
      if (z > (DEG90 <<< 14)) begin
        z -= DEG180 <<< 14; flip = 1;
      end else if (z < -(DEG90 <<< 14)) begin
        z += DEG180 <<< 14; flip = 1;
      end
      x = longint'(two_pkg::CORDIC_GAIN_Q30); y = 0;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x; y = -y;
      end
      mx = rnd_shr(ddy * y, two_pkg::TRIG_BITS) - rnd_shr(ddx * x, two_pkg::TRIG_BITS);
      my = rnd_shr(ddy * x, two_pkg::TRIG_BITS) + rnd_shr(ddx * y, two_pkg::TRIG_BITS);
      fx = fx + mx; fy = fy + my;
      if (fx > 64'sd2147483647) fx = 64'sd2147483647;
      if (fx < -64'sd2147483648) fx = -64'sd2147483648;
      if (fy > 64'sd2147483647) fy = 64'sd2147483647;
      if (fy < -64'sd2147483648) fy = -64'sd2147483648;
      last_h = h; last_v = v; last_hd = hd;
      p.pos_x = fx[31:0]; p.pos_y = fy[31:0]; p.heading = hd;
      pending.push_back(p);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task check_result(logic [95:0] d);
      pose_t p;
      if (pending.size() == 0) begin
        report("unexpected result", longint'($signed(d[31:0])), 0);
        return;
      end
      p = pending.pop_front();
      if ($signed(d[31:0]) != p.pos_x) report("pos_x", $signed(d[31:0]), p.pos_x);
      if ($signed(d[63:32]) != p.pos_y) report("pos_y", $signed(d[63:32]), p.pos_y);
      if ($signed(d[89:64]) != p.heading)
        report("heading_out", $signed(d[89:64]), p.heading);
      if (d[95:90] != 6'd0) report("pad bits", d[95:90], 0);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [95:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  odo_scoreboard sb = new();
  int tx_idle_pct = 14;
  int rx_idle_pct = 58;
  int hold_tokens = 0;
  int hold_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [31:0] walk_h = 0, walk_v = 0;
  longint walk_hd = 0;

  tracking_wheel_odometry_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // result side: check, random stall, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_tokens != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tracking_wheel_odometry_top regression: fail");
      $finish;
    end
  end

  task send_request(logic [31:0] h, logic [31:0] v, longint hd);
    logic [95:0] d;
    int gap;
    d = {6'd0, hd[25:0], v, h};
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(d);
  endtask

  task wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task write_all(logic [23:0] f, logic [23:0] b, logic [23:0] r, logic [23:0] l,
                 logic [1:0] hc, logic [1:0] vc);
    write_reg(two_pkg::REG_FRONT, f);
    write_reg(two_pkg::REG_BACK, b);
    write_reg(two_pkg::REG_RIGHT, r);
    write_reg(two_pkg::REG_LEFT, l);
    write_reg(two_pkg::REG_HCNT, {22'd0, hc});
    write_reg(two_pkg::REG_VCNT, {22'd0, vc});
  endtask

  function longint rand_heading();
    return longint'($urandom_range(0, 47185920)) - DEG360;
  endfunction

  task random_items(int n);
    longint step;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 75) begin
        // smooth motion: small wheel steps, small turns kept in range
        walk_h += $urandom_range(0, 2 * 65536 * 8) - 65536 * 8;
        walk_v += $urandom_range(0, 2 * 65536 * 8) - 65536 * 8;
        step = longint'($urandom_range(0, 2 * 65536 * 20)) - 65536 * 20;
        walk_hd += step;
        if (walk_hd > DEG360 || walk_hd < -DEG360) walk_hd = 0;
        send_request(walk_h, walk_v, walk_hd);
      end else begin
        walk_h = $urandom();
        walk_v = $urandom();
        walk_hd = rand_heading();
        send_request(walk_h, walk_v, walk_hd);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, wrap of the counters, heading fold edges
    send_request(32'h0000_0000, 32'h0000_0000, 0);
    send_request(32'h0001_0000, 32'h0002_0000, 0);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, DEG90);
    send_request(32'h8000_0000, 32'h8000_0000, -DEG90);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, DEG180);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, -DEG180);
    send_request(32'hFFFF_FFFF, 32'h0000_0000, DEG360);
    send_request(32'h0000_1000, 32'h0000_1000, -DEG360);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, DEG360);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, DEG90 + 1);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, DEG180 + 65536);
    send_request(32'h1234_5678, 32'h8765_4321, -DEG180 - 65536);
    wait_drained();
    write_all(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
              two_pkg::CNT_ONE, two_pkg::CNT_ONE);
    write_reg(REG_SPARE_A, 24'hFFFFFF);
    write_reg(REG_SPARE_B, 24'h000000);
    send_request(32'h0, 32'h0, 0);
    send_request(32'h1_0000, 32'h1_0000, DEG180);
    send_request(32'h2_0000, 32'h2_0000, 0);
    send_request(32'h3_0000, 32'h3_0000, -DEG180);
    send_request(32'h3_0000, 32'h3_0000, DEG180);
    wait_drained();
    write_all(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, two_pkg::CNT_THREE, 2'd0);
    send_request(32'h0, 32'h0, DEG180);
    send_request(32'h0, 32'h0, -DEG90);
    send_request(32'h0, 32'h0, DEG90);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin tx_idle_pct = 14; rx_idle_pct = 58; end
        1: begin tx_idle_pct = 58; rx_idle_pct = 14; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (ph)
        0: write_all(24'd0, 24'd0, 24'd0, 24'd0, 2'd0, 2'd0);
        1: write_all(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                     two_pkg::CNT_TWO, two_pkg::CNT_THREE);
        default: write_all(24'($urandom()), 24'($urandom()), 24'($urandom()),
                           24'($urandom()), 2'($urandom_range(0, 3)),
                           2'($urandom_range(0, 3)));
      endcase
      walk_h = $urandom(); walk_v = $urandom(); walk_hd = rand_heading();
      random_items(70);
      if (ph == 0 || ph == 4) hold_tokens++;
      random_items(80);
      wait_drained();
    end

    if (sb.errors == 0)
      $display("tracking_wheel_odometry_top regression: pass");
    else
      $display("tracking_wheel_odometry_top regression: fail");
    $finish;
  end

endmodule
